>>> sv/sorted_priority_queue_defines.svh
// assertion macros used by the sorted priority queue rtl
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define SPQ_ASSERT_ALWAYS(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("spq invariant violated");

// consequence that must hold in the cycle after an antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq sequence violated");

`endif

>>> sv/spq_pkg.sv
// shared types and opcodes of the sorted priority queue
package spq_pkg;

   localparam logic [1:0] OP_ENQ = 2'd0;
   localparam logic [1:0] OP_DEQ = 2'd1;
   localparam logic [1:0] OP_CNT = 2'd2;

   // contents of one queue slot, priority held as raw bits
   typedef struct packed {
      logic        valid;
      logic [31:0] prio;
      logic [31:0] payload;
   } spq_slot_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic        enq;
      logic        deq;
      logic [31:0] prio;
      logic [31:0] payload;
   } spq_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_COUNT  = 3'b010,
      S_FINISH = 3'b100
   } spq_state_type;

endpackage

>>> sv/spq_cell.sv
// one slot of the sorted chain with its insert, shift and count logic
module spq_cell #(
   parameter int CW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spq_pkg::spq_cmd_type cmd,
   input  logic [31:0]          query_prio,
   input  spq_pkg::spq_slot_type left_slot,
   input  logic                 left_keep,
   input  spq_pkg::spq_slot_type right_slot,
   input  logic [CW-1:0]        left_acc,
   output spq_pkg::spq_slot_type slot,
   output logic                 keep,
   output logic [CW-1:0]        acc
);
   import spq_pkg::*;

   spq_slot_type  slot_ff;
   spq_slot_type  slot_in;
   logic [CW-1:0] acc_ff;
   logic [CW-1:0] acc_in;
   logic          match;

   // slot stays when it ranks at or above the new entry
   always_comb begin
      keep = slot_ff.valid && ($signed(cmd.prio) <= $signed(slot_ff.prio));
   end

   // insert here, take the left neighbor, or take the right neighbor
   always_comb begin
      slot_in = slot_ff;
      if (cmd.enq) begin
         if (!keep) begin
            if (left_keep) begin
               slot_in.valid   = 1'b1;
               slot_in.prio    = cmd.prio;
               slot_in.payload = cmd.payload;
            end else begin
               slot_in = left_slot;
            end
         end
      end else if (cmd.deq) begin
         slot_in = right_slot;
      end
   end

   // running match count rippling down the chain
   always_comb begin
      match  = slot_ff.valid && (slot_ff.prio == query_prio);
      acc_in = left_acc + CW'(match);
   end

   // only the valid bit is reset, contents load freely
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
      slot_ff.prio    <= slot_in.prio;
      slot_ff.payload <= slot_in.payload;
      acc_ff          <= acc_in;
   end

   assign slot = slot_ff;
   assign acc  = acc_ff;

endmodule

>>> sv/sorted_priority_queue.sv
// enqueue and dequeue results pass through S_FINISH into the result register, count results
// via S_COUNT and S_FINISH; no new request is taken until S_FINISH hands its result over; a
// count query waits in S_COUNT while the match count ripples along the chain one cell a cycle
// the result register frees the request side while a response beat waits
// reset clears every slot valid bit, the fill count and the response valid
// slot contents are not cleared, and there is no clearing pass
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
   parameter int CAPACITY = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [31:0]                   req_payload,
   input  logic signed [31:0]            req_prio,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_accepted,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_match_count,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_occupancy,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_full,
   output logic [31:0]                   rsp_head_payload,
   output logic signed [31:0]            rsp_head_prio,
   output logic [31:0]                   rsp_tail_payload,
   output logic signed [31:0]            rsp_tail_prio
);
   import spq_pkg::*;

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CNTW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   spq_slot_type  slot_q [CAPACITY];
   logic          keep_v [CAPACITY];
   logic [CW-1:0] acc_v  [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;
   spq_cmd_type   cmd;

   spq_state_type state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [1:0]    op_ff;
   logic          ok_ff;
   logic [31:0]   qprio_ff;
   logic [31:0]   tail_pay_ff;
   logic [31:0]   tail_prio_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_accepted_ff;
   logic [CW-1:0] rsp_match_ff;
   logic [CW-1:0] rsp_occ_ff;
   logic          rsp_empty_ff;
   logic          rsp_full_ff;
   logic [31:0]   rsp_head_pay_ff;
   logic [31:0]   rsp_head_prio_ff;
   logic [31:0]   rsp_tail_pay_ff;
   logic [31:0]   rsp_tail_prio_ff;

   logic accept, full, empty, enq_ok, deq_ok, cnt_op, rsp_load, tail_take;

   // cell chain, front at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_slot_type  l_slot, r_slot;
      logic          l_keep;
      logic [CW-1:0] l_acc;
      if (i == 0) begin : g_front
         assign l_slot = '0;
         assign l_keep = 1'b1;
         assign l_acc  = '0;
      end else begin : g_mid
         assign l_slot = slot_q[i-1];
         assign l_keep = keep_v[i-1];
         assign l_acc  = acc_v[i-1];
      end
      if (i == CAPACITY - 1) begin : g_rear
         assign r_slot = '0;
      end else begin : g_next
         assign r_slot = slot_q[i+1];
      end
      spq_cell #(.CW(CW)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .query_prio (qprio_ff),
         .left_slot  (l_slot),
         .left_keep  (l_keep),
         .right_slot (r_slot),
         .left_acc   (l_acc),
         .slot       (slot_q[i]),
         .keep       (keep_v[i]),
         .acc        (acc_v[i])
      );
      assign valid_vec[i] = slot_q[i].valid;
   end

   // request decode
   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      accept      = req_valid && req_ready;
      full        = (fill_ff == CW'(CAPACITY));
      empty       = (fill_ff == '0);
      enq_ok      = accept && (req_opcode == OP_ENQ) && !full;
      deq_ok      = accept && (req_opcode == OP_DEQ) && !empty;
      cnt_op      = accept && (req_opcode == OP_CNT);
      cmd.enq     = enq_ok;
      cmd.deq     = deq_ok;
      cmd.prio    = req_prio;
      cmd.payload = req_payload;
      tail_take   = enq_ok && (empty || ($signed(req_prio) <= $signed(tail_prio_ff)));
      rsp_load    = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // fill count
   always_comb begin
      fill_in = fill_ff;
      if (enq_ok) begin
         fill_in = fill_ff + CW'(1);
      end else if (deq_ok) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   // sequencer: for a count query wait out the count wave, then hand over the result
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = (req_opcode == OP_CNT) ? S_COUNT : S_FINISH;
            end
         end
         S_COUNT: begin
            if (cnt_ff == CNTW'(CAPACITY - 1)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operation context and rear entry tracking
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (accept) begin
         op_ff    <= req_opcode;
         ok_ff    <= enq_ok || deq_ok || cnt_op;
         qprio_ff <= req_prio;
      end
      if (tail_take) begin
         tail_pay_ff  <= req_payload;
         tail_prio_ff <= req_prio;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_accepted_ff  <= ok_ff;
         rsp_match_ff     <= (op_ff == OP_CNT) ? acc_v[CAPACITY-1] : '0;
         rsp_occ_ff       <= fill_ff;
         rsp_empty_ff     <= empty;
         rsp_full_ff      <= full;
         rsp_head_pay_ff  <= empty ? 32'd0 : slot_q[0].payload;
         rsp_head_prio_ff <= empty ? 32'd0 : slot_q[0].prio;
         rsp_tail_pay_ff  <= empty ? 32'd0 : tail_pay_ff;
         rsp_tail_prio_ff <= empty ? 32'd0 : tail_prio_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_match_count  = rsp_match_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_is_full      = rsp_full_ff;
   assign rsp_head_payload = rsp_head_pay_ff;
   assign rsp_head_prio    = $signed(rsp_head_prio_ff);
   assign rsp_tail_payload = rsp_tail_pay_ff;
   assign rsp_tail_prio    = $signed(rsp_tail_prio_ff);

   // fill count agrees with the valid cells of the chain
   `SPQ_ASSERT_ALWAYS(a_fill_matches_cells, CW'($countones(valid_vec)) == fill_ff)
   // fill count never passes capacity
   `SPQ_ASSERT_ALWAYS(a_fill_bounded, fill_ff <= CW'(CAPACITY))
   // rear entry never ranks above the front entry
   `SPQ_ASSERT_ALWAYS(a_tail_below_head, empty || $signed(tail_prio_ff) <= $signed(slot_q[0].prio))
   // chain holds still while a count wave runs
   `SPQ_ASSERT_NEXT(a_count_stable, state_ff == S_COUNT, $stable(valid_vec))
   // accepted enqueue grows the queue by one
   `SPQ_ASSERT_NEXT(a_enq_grows, enq_ok, fill_ff == $past(fill_ff) + CW'(1))

endmodule
